/* hdl/i2p_pkg.sv */
// Shared types, character codes and lookup functions for the infix to postfix converter.
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

   localparam int STACK_DEPTH_DEF = 32;

   // Operator codes as kept on the stack.
   localparam logic [2:0] CODE_NONE = 3'd0;
   localparam logic [2:0] CODE_LPAR = 3'd1;
   localparam logic [2:0] CODE_ADD  = 3'd2;
   localparam logic [2:0] CODE_SUB  = 3'd3;
   localparam logic [2:0] CODE_MUL  = 3'd4;
   localparam logic [2:0] CODE_DIV  = 3'd5;
   localparam logic [2:0] CODE_POW  = 3'd6;

   // Result status codes.
   localparam logic [1:0] STATUS_CHAR      = 2'd0;
   localparam logic [1:0] STATUS_END       = 2'd1;
   localparam logic [1:0] STATUS_UNMATCHED = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

   localparam logic [7:0] CHAR_LPAR    = 8'h28;
   localparam logic [7:0] CHAR_RPAR    = 8'h29;
   localparam logic [7:0] CHAR_ADD     = 8'h2B;
   localparam logic [7:0] CHAR_SUB     = 8'h2D;
   localparam logic [7:0] CHAR_MUL     = 8'h2A;
   localparam logic [7:0] CHAR_DIV     = 8'h2F;
   localparam logic [7:0] CHAR_POW     = 8'h5E;
   localparam logic [7:0] CHAR_END     = 8'h23;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_NULL    = 8'h00;

   // What the sequencer does with the stack for the current character.
   typedef enum logic [1:0] {
      KIND_CLOSE = 2'd0,
      KIND_END   = 2'd1,
      KIND_PUSH  = 2'd2
   } kind_type;

   // Request to the precedence compare unit.
   typedef struct packed {
      kind_type   kind;
      logic [2:0] new_code;
      logic [2:0] top_code;
   } prec_req_type;

   function automatic logic is_letter(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic [2:0] char_to_code(input logic [7:0] c);
      case (c)
         CHAR_LPAR: return CODE_LPAR;
         CHAR_ADD:  return CODE_ADD;
         CHAR_SUB:  return CODE_SUB;
         CHAR_MUL:  return CODE_MUL;
         CHAR_DIV:  return CODE_DIV;
         CHAR_POW:  return CODE_POW;
         default:   return CODE_NONE;
      endcase
   endfunction

   function automatic logic [7:0] code_to_char(input logic [2:0] code);
      case (code)
         CODE_LPAR: return CHAR_LPAR;
         CODE_ADD:  return CHAR_ADD;
         CODE_SUB:  return CHAR_SUB;
         CODE_MUL:  return CHAR_MUL;
         CODE_DIV:  return CHAR_DIV;
         CODE_POW:  return CHAR_POW;
         default:   return CHAR_NULL;
      endcase
   endfunction

   function automatic logic [1:0] code_level(input logic [2:0] code);
      case (code)
         CODE_ADD, CODE_SUB: return 2'd1;
         CODE_MUL, CODE_DIV: return 2'd2;
         CODE_POW:           return 2'd3;
         default:            return 2'd0;
      endcase
   endfunction

endpackage

`default_nettype wire

/* hdl/i2p_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module i2p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hdl/i2p_prec.sv */
// Precedence compare unit: decides whether the stack top is popped for the current character.
`timescale 1ns / 1ps
`default_nettype none

module i2p_prec (
   input  wire i2p_pkg::prec_req_type req,
   output logic                       pop
);
   import i2p_pkg::*;

   logic [1:0] top_level;
   logic [1:0] new_level;

   assign top_level = code_level(req.top_code);
   assign new_level = code_level(req.new_code);

   always_comb begin
      case (req.kind)
         KIND_CLOSE: pop = (req.top_code != CODE_LPAR);
         KIND_END:   pop = 1'b1;
         KIND_PUSH: begin
            // Equal levels pop, except for the right-associative power operator.
            pop = (req.top_code != CODE_NONE) && (req.top_code != CODE_LPAR) &&
                  (top_level >= new_level) &&
                  !((top_level == new_level) && (req.new_code == CODE_POW));
         end
         default:    pop = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/infix_to_postfix_converter_unit.sv */
// Top level of the infix to postfix converter: sequencer, operator stack and result registers.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_in_char[7:0]
//   rsp     | out       | rsp_valid / rsp_stall | rsp_out_char[7:0], rsp_status[1:0], rsp_last
//
// An ignored byte stays in ST_IDLE, a letter goes on to ST_FLUSH, an open parenthesis to ST_FINISH
// and ST_FLUSH. Other characters pass ST_READ and ST_EVAL per stack entry seen (ST_READ alone on an
// empty stack), then ST_FINISH and ST_FLUSH; each pop waits on the registered stack memory read.
// Reset is synchronous and clears the stack count, the sequencer and the pending and rsp valid flags.
// A stalled rsp beat holds the sequencer only when it has a new result to hand over.
// The next character is taken once the last result of the current one sits in the rsp register.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter_unit #(
   parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_char,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_char,
   output logic [1:0]      rsp_status,
   output logic            rsp_last
);
   import i2p_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_READ   = 5'b00010,
      ST_EVAL   = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_FLUSH  = 5'b10000
   } state_type;

   state_type    state_ff, state_in;
   kind_type     kind_ff, kind_in;
   logic [2:0]   code_ff, code_in;
   logic [CW-1:0] count_ff, count_in;

   logic         pend_valid_ff, pend_valid_in;
   logic [7:0]   pend_char_ff, pend_char_in;
   logic [1:0]   pend_status_ff, pend_status_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_char_ff, rsp_char_in;
   logic [1:0]   rsp_status_ff, rsp_status_in;
   logic         rsp_last_ff, rsp_last_in;

   logic         ram_wr_en;
   logic         ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [2:0]   top_code;

   prec_req_type prec_req;
   logic         prec_pop;

   logic         req_accept;
   logic         out_free;
   logic         can_put;
   logic         put_valid;
   logic [7:0]   put_char;
   logic [1:0]   put_status;
   logic [CW-1:0] count_dec;
   logic         stack_full;
   logic [2:0]   in_code;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // A new result may enter the pending slot if that slot is empty or can move out.
   assign can_put    = !pend_valid_ff || out_free;
   assign count_dec  = count_ff - CW'(1);
   assign stack_full = (count_ff == CW'(STACK_DEPTH));
   assign in_code    = char_to_code(req_in_char);
   assign ram_rd_addr = count_dec[AW-1:0];

   i2p_ram #(
      .WIDTH (3),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (code_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (top_code)
   );

   assign prec_req = '{kind: kind_ff, new_code: code_ff, top_code: top_code};

   i2p_prec u_prec (
      .req (prec_req),
      .pop (prec_pop)
   );

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      code_in    = code_ff;
      count_in   = count_ff;
      ram_wr_en  = 1'b0;
      ram_rd_en  = 1'b0;
      put_valid  = 1'b0;
      put_char   = CHAR_NULL;
      put_status = STATUS_CHAR;

      pend_valid_in  = pend_valid_ff;
      pend_char_in   = pend_char_ff;
      pend_status_in = pend_status_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_char_in   = rsp_char_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (is_letter(req_in_char)) begin
                  pend_valid_in  = 1'b1;
                  pend_char_in   = req_in_char;
                  pend_status_in = STATUS_CHAR;
                  state_in       = ST_FLUSH;
               end else if (req_in_char == CHAR_RPAR) begin
                  kind_in  = KIND_CLOSE;
                  state_in = ST_READ;
               end else if (req_in_char == CHAR_END) begin
                  kind_in  = KIND_END;
                  state_in = ST_READ;
               end else if (in_code != CODE_NONE) begin
                  kind_in  = KIND_PUSH;
                  code_in  = in_code;
                  state_in = (in_code == CODE_LPAR) ? ST_FINISH : ST_READ;
               end
            end
         end
         ST_READ: begin
            if (count_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (prec_pop) begin
               put_valid  = 1'b1;
               put_char   = code_to_char(top_code);
               put_status = STATUS_CHAR;
               if (can_put) begin
                  count_in = count_dec;
                  state_in = ST_READ;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            case (kind_ff)
               KIND_CLOSE: begin
                  if (count_ff != '0) begin
                     // The matching open parenthesis is dropped without a result.
                     count_in = count_dec;
                     state_in = ST_FLUSH;
                  end else begin
                     put_valid  = 1'b1;
                     put_status = STATUS_UNMATCHED;
                     if (can_put) begin
                        state_in = ST_FLUSH;
                     end
                  end
               end
               KIND_END: begin
                  put_valid  = 1'b1;
                  put_char   = CHAR_NEWLINE;
                  put_status = STATUS_END;
                  if (can_put) begin
                     state_in = ST_FLUSH;
                  end
               end
               KIND_PUSH: begin
                  if (stack_full) begin
                     put_valid  = 1'b1;
                     put_status = STATUS_OVERFLOW;
                     if (can_put) begin
                        state_in = ST_FLUSH;
                     end
                  end else begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + CW'(1);
                     state_in  = ST_FLUSH;
                  end
               end
               default: begin
                  state_in = ST_FLUSH;
               end
            endcase
         end
         ST_FLUSH: begin
            // The held result is the final one for this character.
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = pend_char_ff;
               rsp_status_in = pend_status_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (put_valid && can_put) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_char_in   = pend_char_ff;
            rsp_status_in = pend_status_ff;
            rsp_last_in   = 1'b0;
         end
         pend_valid_in  = 1'b1;
         pend_char_in   = put_char;
         pend_status_in = put_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      code_ff        <= code_in;
      pend_char_ff   <= pend_char_in;
      pend_status_ff <= pend_status_in;
      rsp_char_ff    <= rsp_char_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;

`ifndef SYNTH
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count exceeds the stack depth");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("a result is still pending while the sequencer is idle");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("a stack write did not advance the stack count");

   a_accept_when_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept && is_letter(req_in_char) |=> (state_ff == ST_FLUSH) && pend_valid_ff)
      else $error("a letter beat did not reach the pending slot");
`endif

endmodule

`default_nettype wire
